@@ rtl/rlrn_pkg.sv @@
// shared types and constants for the residual add and layer / rms norm block
// no dependencies
package rlrn_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int IDX_W = $clog2(MAX_CHANNELS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ELEM = 1'b1;

    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_EPSILON  = 3'd1;
    localparam logic [2:0] REG_RMS      = 3'd2;
    localparam logic [2:0] REG_RESIDUAL = 3'd3;
    localparam logic [2:0] REG_AFFINE   = 3'd4;

    typedef struct packed {
        logic [6:0]  channels;
        logic [15:0] epsilon;
        logic        rms_mode;
        logic        residual_enable;
        logic        affine_enable;
    } cfg_t;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) return 16'sh7fff;
        if (v < -48'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

@@ rtl/rlrn_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
// depends on rlrn_pkg
module rlrn_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [48:0] dividend,
    input  logic [48:0] divisor,
    output logic        done,
    output logic [48:0] quotient
);
    import rlrn_pkg::*;

    logic [48:0] q_reg, r_reg, d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [49:0] rs;

    assign rs = {r_reg, q_reg[48]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
                cnt_reg  <= 6'd48;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (rs >= {1'b0, d_reg}) begin
                    r_reg <= 49'(rs - {1'b0, d_reg});
                    q_reg <= {q_reg[47:0], 1'b1};
                end else begin
                    r_reg <= rs[48:0];
                    q_reg <= {q_reg[47:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/rlrn_mem.sv @@
// row memory and a shared gamma / beta memory, one write and one registered read each
// depends on rlrn_pkg
module rlrn_mem (
    input  logic                      aclk,
    input  logic                      row_we,
    input  logic [rlrn_pkg::IDX_W-1:0] row_waddr,
    input  logic [15:0]               row_wdata,
    input  logic                      gb_we,
    input  logic [rlrn_pkg::IDX_W-1:0] gb_waddr,
    input  logic [31:0]               gb_wdata,
    input  logic [rlrn_pkg::IDX_W-1:0] raddr,
    output logic [15:0]               row_rdata,
    output logic [31:0]               gb_rdata
);
    import rlrn_pkg::*;

    logic [15:0] row_mem [MAX_CHANNELS];
    logic [31:0] gb_mem  [MAX_CHANNELS];

    always_ff @(posedge aclk) begin
        if (row_we) row_mem[row_waddr] <= row_wdata;
        if (gb_we) gb_mem[gb_waddr] <= gb_wdata;
        row_rdata <= row_mem[raddr];
        gb_rdata  <= gb_mem[raddr];
    end

endmodule

@@ rtl/residual_layer_rms_norm.sv @@
// channel  | dir | payload
// s_axis   | in  | tuser: opcode ; tdata: entry_index, gamma_value, beta_value, sample, residual
// m_axis   | out | tdata: norm_value, sum_value ; tlast: last
// cfg      | in  | cfg_we, cfg_index, cfg_wdata
// elements are taken back to back while the block waits for input; the last element
// of a row starts the work: the mean (layer mode only), the sum of squares, the
// variance divide, then, unless v (variance plus epsilon) is zero, the 2^48/v divide and
// the square root search, the set-up and the emit beats; each emit beat waits on m_tready.
// reset is synchronous; the row, gamma and beta memories are not cleared.
// no input is taken while a row is being normalized or emitted.
// depends on rlrn_pkg, rlrn_mem, rlrn_div
module residual_layer_rms_norm (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // opcode
    input  logic [71:0] s_tdata,   // entry_index, gamma, beta, sample, residual
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // norm_value, sum_value
    output logic        m_tlast    // last
);
    import rlrn_pkg::*;

    typedef enum logic [3:0] {
        S_IN, S_MEAN, S_SQ, S_VDIV, S_VWAIT, S_LDIV, S_LWAIT, S_SQRT,
        S_RD, S_MUL, S_AFF, S_OUT
    } state_t;

    state_t state_reg;
    cfg_t   cfg_reg;
    logic [CNT_W-1:0] cnt_reg, idx_reg;
    logic signed [21:0] sum_reg;
    logic signed [21:0] mean_reg;
    logic [47:0] sumsq_reg;
    logic [48:0] lim_reg;
    logic [23:0] inv_reg;
    logic [4:0]  bit_reg;
    logic        aff_reg, rdv_reg;
    logic signed [15:0] x_reg, g_reg, b_reg, norm_reg;
    logic signed [41:0] prod_reg;
    logic [31:0] out_reg;
    logic        outv_reg, outl_reg;

    logic        opcode;
    logic [5:0]  entry_index;
    logic signed [15:0] gamma_value, beta_value, sample, residual;
    assign opcode      = s_tuser;
    assign entry_index = s_tdata[5:0];
    assign gamma_value = s_tdata[21:6];
    assign beta_value  = s_tdata[37:22];
    assign sample      = s_tdata[53:38];
    assign residual    = s_tdata[69:54];

    logic [CNT_W-1:0] eff;
    always_comb begin
        eff = cfg_reg.channels[CNT_W-1:0];
        if (cfg_reg.channels == '0) eff = CNT_W'(1);
        if (cfg_reg.channels > 7'(MAX_CHANNELS)) eff = CNT_W'(MAX_CHANNELS);
    end

    logic acc;
    assign s_tready = (state_reg == S_IN);
    assign acc = s_tvalid && s_tready;

    logic signed [15:0] s_val;
    assign s_val = cfg_reg.residual_enable
        ? sat16(48'(sample) + 48'(residual)) : sample;

    logic row_we, gb_we;
    assign row_we = acc && opcode == OP_ELEM && cnt_reg < CNT_W'(MAX_CHANNELS);
    assign gb_we  = acc && opcode == OP_LOAD;

    logic [IDX_W-1:0] raddr;
    logic [15:0] row_rdata;
    logic [31:0] gb_rdata;
    assign raddr = idx_reg[IDX_W-1:0];

    rlrn_mem u_mem (
        .aclk(aclk), .row_we(row_we), .row_waddr(cnt_reg[IDX_W-1:0]),
        .row_wdata(s_val), .gb_we(gb_we), .gb_waddr(entry_index),
        .gb_wdata({beta_value, gamma_value}), .raddr(raddr),
        .row_rdata(row_rdata), .gb_rdata(gb_rdata)
    );

    logic        div_start, div_done;
    logic [48:0] div_a, div_b, div_q;
    assign div_start = (state_reg == S_VDIV) || (state_reg == S_LDIV);
    assign div_a = (state_reg == S_VDIV) ? {1'b0, sumsq_reg} : 49'(64'h1_0000_0000_0000);
    assign div_b = (state_reg == S_VDIV) ? 49'(cnt_reg) : lim_reg;

    rlrn_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    // magnitude of the row sum for the mean division
    logic [21:0] abs_sum;
    assign abs_sum = sum_reg[21] ? 22'(-sum_reg) : 22'(sum_reg);

    logic signed [16:0] d_c;
    assign d_c = 17'(signed'(row_rdata)) - 17'(mean_reg);
    logic [23:0] cand;
    logic [47:0] cand_sq;
    assign cand    = inv_reg | (24'd1 << bit_reg);
    assign cand_sq = cand * cand;

    logic signed [47:0] rnd, aff_p;
    assign rnd   = (48'(prod_reg) + 48'sd32768) >>> 16;
    assign aff_p = (48'(norm_reg) * 48'(g_reg) + 48'sd128) >>> 8;

    logic mean_pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IN;
            cfg_reg   <= '{channels: 7'd64, epsilon: 16'd1, rms_mode: 1'b0,
                           residual_enable: 1'b0, affine_enable: 1'b0};
            cnt_reg   <= '0;
            sum_reg   <= '0;
            outv_reg  <= 1'b0;
            rdv_reg   <= 1'b0;
            mean_pend_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_CHANNELS: cfg_reg.channels        <= cfg_wdata[6:0];
                    REG_EPSILON:  cfg_reg.epsilon         <= cfg_wdata;
                    REG_RMS:      cfg_reg.rms_mode        <= cfg_wdata[0];
                    REG_RESIDUAL: cfg_reg.residual_enable <= cfg_wdata[0];
                    REG_AFFINE:   cfg_reg.affine_enable   <= cfg_wdata[0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IN: begin
                    if (acc && opcode == OP_ELEM) begin
                        logic [CNT_W-1:0] nc;
                        nc = row_we ? cnt_reg + CNT_W'(1) : cnt_reg;
                        cnt_reg <= nc;
                        if (row_we) sum_reg <= sum_reg + 22'(s_val);
                        if (nc >= eff) state_reg <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    // mean (layer mode only): |sum| / n one quotient bit per cycle, then the sign
                    mean_reg  <= '0;
                    lim_reg   <= 49'(abs_sum);
                    bit_reg   <= 5'd21;
                    sumsq_reg <= '0;
                    idx_reg   <= '0;
                    rdv_reg   <= 1'b0;
                    aff_reg   <= cfg_reg.affine_enable;
                    if (cfg_reg.rms_mode) begin
                        state_reg <= S_SQ;
                    end else begin
                        mean_pend_reg <= 1'b1;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (mean_pend_reg) begin
                        // one quotient bit per cycle of |sum| / n
                        if (lim_reg >= (49'(cnt_reg) << bit_reg)) begin
                            lim_reg <= lim_reg - (49'(cnt_reg) << bit_reg);
                            mean_reg <= mean_reg | (22'sd1 << bit_reg);
                        end
                        if (bit_reg == '0) begin
                            mean_pend_reg <= 1'b0;
                        end
                        bit_reg <= bit_reg - 5'd1;
                    end else if (sum_reg[21] && !cfg_reg.rms_mode && !mean_reg[21]
                                 && mean_reg != '0 && !rdv_reg && idx_reg == '0) begin
                        mean_reg <= -mean_reg;
                        rdv_reg <= 1'b1;
                    end else begin
                        if (idx_reg != cnt_reg) idx_reg <= idx_reg + CNT_W'(1);
                        if (idx_reg != '0) sumsq_reg <= sumsq_reg + 48'(d_c * d_c);
                        if (idx_reg == cnt_reg) state_reg <= S_VDIV;
                    end
                end
                S_VDIV: state_reg <= S_VWAIT;
                S_VWAIT: if (div_done) begin
                    lim_reg   <= div_q + 49'(cfg_reg.epsilon);
                    state_reg <= (div_q + 49'(cfg_reg.epsilon) == '0) ? S_RD : S_LDIV;
                    inv_reg   <= 24'hffffff;
                end
                S_LDIV: state_reg <= S_LWAIT;
                S_LWAIT: if (div_done) begin
                    lim_reg   <= div_q;
                    inv_reg   <= '0;
                    bit_reg   <= 5'd23;
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    if (49'(cand_sq) <= lim_reg) inv_reg <= cand;
                    bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == '0) state_reg <= S_RD;
                end
                S_RD: begin
                    if (!outv_reg || m_tready) begin
                        outv_reg <= 1'b0;
                        idx_reg  <= '0;
                        state_reg <= S_MUL;
                        rdv_reg  <= 1'b0;
                    end
                end
                S_MUL: begin
                    if (!rdv_reg) begin
                        rdv_reg <= 1'b1;
                    end else begin
                        x_reg    <= row_rdata;
                        g_reg    <= gb_rdata[15:0];
                        b_reg    <= gb_rdata[31:16];
                        prod_reg <= 42'(d_c) * 42'(signed'({1'b0, inv_reg}));
                        state_reg <= S_AFF;
                    end
                end
                S_AFF: begin
                    norm_reg <= sat16(rnd);
                    state_reg <= S_OUT;
                    rdv_reg  <= 1'b0;
                end
                S_OUT: begin
                    if (!rdv_reg) begin
                        out_reg[15:0]  <= aff_reg ? sat16(aff_p + 48'(b_reg)) : norm_reg;
                        out_reg[31:16] <= x_reg;
                        outl_reg <= (idx_reg + CNT_W'(1) == cnt_reg);
                        outv_reg <= 1'b1;
                        rdv_reg  <= 1'b1;
                    end else if (m_tready) begin
                        outv_reg <= 1'b0;
                        rdv_reg  <= 1'b0;
                        if (outl_reg) begin
                            cnt_reg   <= '0;
                            sum_reg   <= '0;
                            state_reg <= S_IN;
                        end else begin
                            idx_reg   <= idx_reg + CNT_W'(1);
                            state_reg <= S_MUL;
                        end
                    end
                end
                default: state_reg <= S_IN;
            endcase
        end
    end

    assign m_tvalid = outv_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = outl_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IN) |-> !s_tready) else $error("input taken while busy");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_CHANNELS)) else $error("element count overflow");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
`endif

endmodule

@@ test/tb_residual_layer_rms_norm.sv @@
// testbench for residual_layer_rms_norm: directed rows then random rows under random
// flow control, checked beat by beat against an in-bench fixed-point norm predictor
// depends on rlrn_pkg and the residual_layer_rms_norm rtl
module tb_residual_layer_rms_norm;
    timeunit 1ns;
    timeprecision 1ps;
    import rlrn_pkg::*;

    typedef struct {
        logic [15:0] norm;
        logic [15:0] sum;
        logic        last;
    } norm_beat_t;

    localparam int DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 1000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    residual_layer_rms_norm i_dut (.*);

    // predictor state
    logic signed [15:0] row_buf [MAX_CHANNELS];
    logic signed [15:0] gamma_tab [MAX_CHANNELS];
    logic signed [15:0] beta_tab [MAX_CHANNELS];
    int                 elem_cnt = 0;
    int                 row_acc = 0;
    cfg_t               cfg_shadow = '{channels: 7'd64, epsilon: 16'd1, rms_mode: 1'b0,
                                       residual_enable: 1'b0, affine_enable: 1'b0};

    // item: opcode in bit 0, then entry_index, gamma, beta, sample, residual
    logic [70:0] pending_beats[$];
    norm_beat_t  expected_beats[$];
    int          err_count = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          rows_done = 0;
    longint      cycle_cnt = 0;
    bit          hold_req = 1'b0;
    bit          s_took = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          rx_mode = 0;
    int          rx_left = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint unsigned inv_root(longint unsigned v);
        longint unsigned lim;
        longint unsigned y;
        longint unsigned c;
        y = 0;
        if (v == 0) return 64'hFFFFFF;
        lim = (64'd1 << 48) / v;
        for (int b = 23; b >= 0; b--) begin
            c = y | (64'd1 << b);
            if (c * c <= lim) y = c;
        end
        return y;
    endfunction

    task automatic predict_beat(input logic [70:0] d);
        logic signed [15:0] smp;
        logic signed [15:0] res;
        logic signed [15:0] s;
        int                 eff;
        int                 n;
        int                 mean;
        longint             diff;
        longint unsigned    sumsq;
        longint unsigned    inv;
        longint             v;
        norm_beat_t         nb;
        if (d[0] == OP_LOAD) begin
            gamma_tab[d[6:1]] = d[22:7];
            beta_tab[d[6:1]] = d[38:23];
            return;
        end
        smp = d[54:39];
        res = d[70:55];
        eff = cfg_shadow.channels;
        if (eff == 0) eff = 1;
        if (eff > MAX_CHANNELS) eff = MAX_CHANNELS;
        s = cfg_shadow.residual_enable ? clip16(longint'(smp) + longint'(res)) : smp;
        if (elem_cnt < MAX_CHANNELS) begin
            row_buf[elem_cnt] = s;
            elem_cnt++;
            row_acc += s;
        end
        if (elem_cnt < eff) return;
        n = elem_cnt;
        mean = cfg_shadow.rms_mode ? 0 : row_acc / n;
        sumsq = 0;
        for (int i = 0; i < n; i++) begin
            diff = longint'(row_buf[i]) - mean;
            sumsq += diff * diff;
        end
        inv = inv_root(sumsq / n + cfg_shadow.epsilon);
        for (int i = 0; i < n; i++) begin
            diff = longint'(row_buf[i]) - mean;
            v = clip16((diff * longint'(inv) + 64'sd32768) >>> 16);
            if (cfg_shadow.affine_enable)
                v = clip16(((v * longint'(gamma_tab[i]) + 64'sd128) >>> 8)
                           + longint'(beta_tab[i]));
            nb.norm = v[15:0];
            nb.sum = row_buf[i];
            nb.last = (i + 1 == n);
            expected_beats.push_back(nb);
        end
        elem_cnt = 0;
        row_acc = 0;
        rows_done++;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s at beat %0d: got %0d want %0d", what, beats_out, got, want);
        err_count++;
    endtask

    // sender: bursts with gaps, holds data until taken
    always @(negedge aclk) begin
        logic        nxt_valid;
        logic [70:0] nxt_item;
        nxt_valid = s_tvalid;
        nxt_item = {s_tdata[69:0], s_tuser};
        if (!s_tvalid || s_took) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_beats.size() > 0) begin
                nxt_item = pending_beats.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tuser <= nxt_item[0];
        s_tdata <= {2'b00, nxt_item[70:1]};
    end

    // receiver: own stall pattern plus one long hold-off on request
    always @(negedge aclk) begin
        logic rdy;
        if (hold_req) begin
            hold_left = 700;
            hold_req = 1'b0;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        case (rx_mode)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1);
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = ($urandom_range(0, 7) != 0);
        endcase
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end
        m_tready <= aresetn ? rdy : 1'b0;
    end

    // monitor
    always @(posedge aclk) begin
        norm_beat_t nb;
        cycle_cnt++;
        s_took <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            beats_in++;
            predict_beat({s_tdata[69:0], s_tuser});
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[15:0], 0);
            end else begin
                nb = expected_beats.pop_front();
                if (m_tdata[15:0] !== nb.norm)
                    report_mismatch("norm", $signed(m_tdata[15:0]), $signed(nb.norm));
                if (m_tdata[31:16] !== nb.sum)
                    report_mismatch("sum", $signed(m_tdata[31:16]), $signed(nb.sum));
                if (m_tlast !== nb.last)
                    report_mismatch("tlast", m_tlast, nb.last);
            end
            beats_out++;
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [70:0] load_beat(int idx, logic [15:0] g, logic [15:0] b);
        logic [70:0] d;
        d = '0;
        d[0] = OP_LOAD;
        d[6:1] = 6'(idx);
        d[22:7] = g;
        d[38:23] = b;
        d[54:39] = 16'($urandom);
        d[70:55] = 16'($urandom);
        return d;
    endfunction

    function automatic logic [70:0] elem_beat(logic [15:0] smp, logic [15:0] res);
        logic [70:0] d;
        d = '0;
        d[0] = OP_ELEM;
        d[6:1] = 6'($urandom);
        d[22:7] = 16'($urandom);
        d[38:23] = 16'($urandom);
        d[54:39] = smp;
        d[70:55] = res;
        return d;
    endfunction

    function automatic logic [15:0] rand_sample(int kind);
        case (kind)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 1023)) - 512);
            2: return ($urandom_range(0, 1) == 0) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 63)) - 32);
        endcase
    endfunction

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_beats.size() > 0 || s_tvalid || expected_beats.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CHANNELS: cfg_shadow.channels = val[6:0];
            REG_EPSILON:  cfg_shadow.epsilon = val;
            REG_RMS:      cfg_shadow.rms_mode = val[0];
            REG_RESIDUAL: cfg_shadow.residual_enable = val[0];
            REG_AFFINE:   cfg_shadow.affine_enable = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_row(int len, int kind);
        logic [15:0] flat;
        flat = rand_sample(kind);
        for (int i = 0; i < len; i++)
            pending_beats.push_back(elem_beat(kind == 4 ? flat : rand_sample(kind),
                                              rand_sample($urandom_range(0, 3))));
    endtask

    initial begin
        int       row_len;
        int       rows_total;
        bit       held;
        int       picks[8] = '{1, 2, 3, 4, 5, 8, 16, 64};
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // extremes of the sample field
        write_reg(REG_CHANNELS, 16'd4);
        pending_beats.push_back(elem_beat(16'h7fff, 16'h0));
        pending_beats.push_back(elem_beat(16'h8000, 16'h0));
        pending_beats.push_back(elem_beat(16'h0000, 16'h0));
        pending_beats.push_back(elem_beat(16'h0001, 16'h0));
        // flat row, no epsilon: inverse root saturates
        write_reg(REG_EPSILON, 16'd0);
        push_row(4, 4);
        // residual add with saturation both ways
        write_reg(REG_RESIDUAL, 16'd1);
        write_reg(REG_EPSILON, 16'hffff);
        pending_beats.push_back(elem_beat(16'h7fff, 16'h7fff));
        pending_beats.push_back(elem_beat(16'h8000, 16'h8000));
        pending_beats.push_back(elem_beat(16'd100, -16'sd50));
        pending_beats.push_back(elem_beat(16'h0000, 16'h0000));
        write_reg(REG_RMS, 16'd1);
        push_row(4, 1);
        // row length lowered mid-row
        write_reg(REG_CHANNELS, 16'd8);
        push_row(3, 1);
        write_reg(REG_CHANNELS, 16'd2);
        push_row(1, 1);
        // zero channels act as one
        write_reg(REG_CHANNELS, 16'd0);
        push_row(2, 0);
        // gamma / beta table, all entries, extremes first
        write_reg(REG_RMS, 16'd0);
        pending_beats.push_back(load_beat(0, 16'h7fff, 16'h8000));
        pending_beats.push_back(load_beat(1, 16'h8000, 16'h7fff));
        for (int i = 2; i < MAX_CHANNELS; i++)
            pending_beats.push_back(load_beat(i, $urandom_range(0, 3) == 0 ? 16'($urandom)
                                              : 16'($signed($urandom_range(0, 1023)) - 512),
                                              16'($urandom)));
        write_reg(REG_AFFINE, 16'd1);
        write_reg(REG_CHANNELS, 16'd4);
        push_row(4, 2);
        push_row(4, 0);
        // oversized channel count acts as the maximum
        write_reg(REG_CHANNELS, 16'd127);
        push_row(64, 1);

        held = 1'b0;
        while (beats_in < 370) begin
            row_len = picks[$urandom_range(0, 6)];
            if ($urandom_range(0, 9) == 0) row_len = 64;
            write_reg(REG_CHANNELS, 16'(row_len));
            case ($urandom_range(0, 3))
                0: write_reg(REG_EPSILON, 16'd0);
                1: write_reg(REG_EPSILON, 16'd1);
                2: write_reg(REG_EPSILON, 16'hffff);
                default: write_reg(REG_EPSILON, 16'($urandom));
            endcase
            write_reg(REG_RMS, 16'($urandom_range(0, 1)));
            write_reg(REG_RESIDUAL, 16'($urandom_range(0, 1)));
            write_reg(REG_AFFINE, 16'($urandom_range(0, 1)));
            rows_total = (row_len >= 16) ? 1 : $urandom_range(2, 6);
            if (!held && beats_in > 250) begin
                hold_req = 1'b1;
                held = 1'b1;
                if (rows_total < 2) rows_total = 2;
            end
            for (int r = 0; r < rows_total; r++) begin
                if ($urandom_range(0, 4) == 0)
                    pending_beats.push_back(load_beat($urandom_range(0, 63), 16'($urandom),
                                                      16'($urandom)));
                push_row(row_len, $urandom_range(0, 4));
            end
        end

        wait_idle();
        $display("%0d input beats, %0d rows, %0d result beats over layer and rms modes",
                 beats_in, rows_done, beats_out);
        if (err_count == 0 && expected_beats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d beats still expected", err_count,
                     expected_beats.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
